>>> src/assert_macros.svh
//------------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL.
//------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge of clk outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a trigger implies a consequence in the next cycle.
`define ASSERT_NEXT(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

>>> src/ptq_pkg.sv
//------------------------------------------------------------------------------
// ptq_pkg
// Shared types and codes of the priority task queue.
//------------------------------------------------------------------------------
package ptq_pkg;

	localparam int ID_W   = 16;
	localparam int PRIO_W = 8;

	typedef enum logic {
		MODE_PUSH = 1'b0,
		MODE_POP  = 1'b1
	} mode_t;

	typedef enum logic [1:0] {
		ST_PUSHED     = 2'd0,
		ST_PUSH_FULL  = 2'd1,
		ST_POPPED     = 2'd2,
		ST_POP_EMPTY  = 2'd3
	} status_t;

	// contents of one queue cell
	typedef struct packed {
		logic              valid;
		logic [ID_W-1:0]   id;
		logic [PRIO_W-1:0] prio;
	} slot_t;

	// operation broadcast to every cell
	typedef struct packed {
		logic              push;
		logic              pop;
		logic [ID_W-1:0]   id;
		logic [PRIO_W-1:0] prio;
	} cmd_t;

endpackage

>>> src/ptq_cell.sv
//------------------------------------------------------------------------------
// ptq_cell
// One cell of the sorted chain: holds a task, shifts on push and pop.
//------------------------------------------------------------------------------
module ptq_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  ptq_pkg::cmd_t  cmd,
	input  ptq_pkg::slot_t prev_slot,
	input  logic           prev_ge,
	input  ptq_pkg::slot_t next_slot,
	output ptq_pkg::slot_t slot,
	output logic           ge
);

	logic           valid_q;
	logic [ptq_pkg::ID_W-1:0]   id_q;
	logic [ptq_pkg::PRIO_W-1:0] prio_q;
	ptq_pkg::slot_t slot_d;
	logic           load;

	// stored task ranks at or above the incoming one: stay put
	assign ge = valid_q && (prio_q >= cmd.prio);

	always_comb begin
		slot_d = '{valid: valid_q, id: id_q, prio: prio_q};
		load   = 1'b0;
		if (cmd.pop) begin
			slot_d = next_slot;
			load   = 1'b1;
		end else if (cmd.push && !ge) begin
			load = 1'b1;
			if (prev_ge) begin
				slot_d = '{valid: 1'b1, id: cmd.id, prio: cmd.prio};
			end else begin
				slot_d = prev_slot;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= slot_d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			id_q   <= slot_d.id;
			prio_q <= slot_d.prio;
		end
	end

	assign slot = '{valid: valid_q, id: id_q, prio: prio_q};

endmodule

>>> src/priority_task_queue.sv
//------------------------------------------------------------------------------
// priority_task_queue
// Max-priority task queue built as a sorted shift chain of cells.
//------------------------------------------------------------------------------
// Each transfer on the input stream is a push (tuser 0: store task id and
// priority) or a pop (tuser 1: remove the highest priority task). Every
// transfer yields exactly one output transfer carrying a status in tuser and,
// for a successful pop, the task id and priority in tdata. Equal priorities
// leave in push order. A push into a full queue is dropped with status 1; a
// pop on an empty queue returns status 3. One item is taken per cycle while
// the sink keeps up: the cells compare against the incoming priority in
// parallel and shift together, and the output register frees itself whenever
// the sink takes data, so a new item is accepted in the same cycle a result is
// consumed. Output valid is registered and rises in the cycle after the input
// transfer. No clearing pass is needed after reset; only valid bits are reset.
//------------------------------------------------------------------------------
`include "assert_macros.svh"

module priority_task_queue #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // [15:0] task_id, [23:16] priority_req
	input  logic        s_axis_tuser,   // [0] mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [15:0] out_task_id, [23:16] out_priority
	output logic [1:0]  m_axis_tuser    // [1:0] status
);

	ptq_pkg::slot_t slots [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] ge;
	logic [QUEUE_DEPTH-1:0] valid_vec;
	ptq_pkg::cmd_t  cmd;

	logic in_xfer;
	logic is_pop;
	logic full;
	logic empty;

	logic                         out_valid_q;
	ptq_pkg::status_t             out_status_q;
	logic [ptq_pkg::ID_W-1:0]     out_id_q;
	logic [ptq_pkg::PRIO_W-1:0]   out_prio_q;

	// Take a new item whenever the output register is empty or being drained.
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign is_pop        = (ptq_pkg::mode_t'(s_axis_tuser) == ptq_pkg::MODE_POP);

	// Occupied cells form a prefix, so the ends of the chain give full/empty.
	assign full  = slots[QUEUE_DEPTH-1].valid;
	assign empty = !slots[0].valid;

	// Broadcast the operation; drop pushes into a full queue, pops on empty.
	assign cmd.push = in_xfer && !is_pop && !full;
	assign cmd.pop  = in_xfer && is_pop && !empty;
	assign cmd.id   = s_axis_tdata[15:0];
	assign cmd.prio = s_axis_tdata[23:16];

	// Cell 0 sees a virtual head that always ranks above the new task; the last
	// cell pulls an empty slot on pop.
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		ptq_pkg::slot_t prev_slot;
		ptq_pkg::slot_t next_slot;
		logic           prev_ge;

		if (i == 0) begin : g_head
			assign prev_slot = '{valid: 1'b1, id: '0, prio: '0};
			assign prev_ge   = 1'b1;
		end else begin : g_body
			assign prev_slot = slots[i-1];
			assign prev_ge   = ge[i-1];
		end

		if (i == QUEUE_DEPTH-1) begin : g_tail
			assign next_slot = '0;
		end else begin : g_mid
			assign next_slot = slots[i+1];
		end

		ptq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.prev_slot (prev_slot),
			.prev_ge   (prev_ge),
			.next_slot (next_slot),
			.slot      (slots[i]),
			.ge        (ge[i])
		);

		assign valid_vec[i] = slots[i].valid;
	end

	// Output register: hold until the sink takes the transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			out_id_q   <= '0;
			out_prio_q <= '0;
			if (!is_pop) begin
				out_status_q <= full ? ptq_pkg::ST_PUSH_FULL : ptq_pkg::ST_PUSHED;
			end else if (empty) begin
				out_status_q <= ptq_pkg::ST_POP_EMPTY;
			end else begin
				out_status_q <= ptq_pkg::ST_POPPED;
				out_id_q     <= slots[0].id;
				out_prio_q   <= slots[0].prio;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_prio_q, out_id_q};
	assign m_axis_tuser  = out_status_q;

	// Checks on chain ordering and occupancy.
	logic [QUEUE_DEPTH-2:0] order_ok;
	for (genvar i = 0; i < QUEUE_DEPTH-1; i++) begin : g_order
		assign order_ok[i] = !slots[i+1].valid ||
			(slots[i].valid && (slots[i].prio >= slots[i+1].prio));
	end

	logic [QUEUE_DEPTH:0] prefix_chk;
	assign prefix_chk = {1'b0, valid_vec} + {{QUEUE_DEPTH{1'b0}}, 1'b1};

	`ASSERT_ALWAYS(a_prefix, $onehot(prefix_chk), "occupied cells are not a prefix")
	`ASSERT_ALWAYS(a_sorted, &order_ok, "chain priorities out of order")
	`ASSERT_NEXT(a_pop_empty, in_xfer && is_pop && empty,
		m_axis_tvalid && (m_axis_tuser == ptq_pkg::ST_POP_EMPTY), "pop on empty not reported")
	`ASSERT_NEXT(a_push_grow, cmd.push,
		$countones(valid_vec) == $countones($past(valid_vec)) + 1, "push did not add a task")

endmodule
